FILE: rtl/sprt_pkg.sv
// ----------------------------------------------------------------------------
// Shared page reference count table package
// Sizes, status codes, state type and the structs that pass between the
// sequencer, the slot store and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sprt_pkg;

	// Table geometry.
	localparam int SLOT_COUNT = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ID_BITS    = 31;

	// Widths of the result fields on the ports.
	localparam int SLOT_OUT_BITS  = 4;
	localparam int COUNT_OUT_BITS = 16;

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_ID    = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_AT_MAX    = 3'd4
	} status_t;

	// Requested operation.
	typedef enum logic {
		ACT_OPEN  = 1'b0,
		ACT_CLOSE = 1'b1
	} action_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// Write request into the slot store.
	typedef struct packed {
		logic                  en;
		logic [IDX_BITS-1:0]   idx;
		logic [ID_BITS-1:0]    id;
		logic [COUNT_BITS-1:0] count;
	} wr_req_t;

	// Read data from the slot store.
	typedef struct packed {
		logic [ID_BITS-1:0]    id;
		logic [COUNT_BITS-1:0] count;
	} slot_rd_t;

	// Result of one transaction as produced by the sequencer.
	typedef struct packed {
		logic                  valid;
		status_t               status;
		logic [IDX_BITS-1:0]   idx;
		logic                  claimed;
		logic                  freed;
		logic [COUNT_BITS-1:0] count;
	} result_t;

	// Fit a slot index to the result port width.
	function automatic logic [SLOT_OUT_BITS-1:0] fit_slot(input logic [IDX_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[SLOT_OUT_BITS-1:0];
	endfunction

	// Fit a reference count to the result port width.
	function automatic logic [COUNT_OUT_BITS-1:0] fit_count(input logic [COUNT_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[COUNT_OUT_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/shared_page_refcount_table.sv
// ----------------------------------------------------------------------------
// Shared page reference count table
// Open and close requests on a table of shared segment slots, one result
// per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The slots are
// walked one per cycle through a single id comparator, stopping at the first
// slot that holds the id or after the last slot, followed by the update
// state; the result is shown on the cycle after that, marked by done, for
// exactly one cycle and cannot be held off. The block stays busy through the
// scan and the update, and the next request can be taken in the cycle the
// result is shown; a request with a non-positive id skips the scan.
// Reset frees every slot at once, with no clearing pass.
`default_nettype none

module shared_page_refcount_table
	import sprt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      action,
	input  wire logic signed [31:0]        segment_id,
	output logic                           done,
	output logic [2:0]                     status,
	output logic [SLOT_OUT_BITS-1:0]       slot_index,
	output logic                           newly_claimed,
	output logic                           slot_freed,
	output logic [COUNT_OUT_BITS-1:0]      ref_count
);

	logic [IDX_BITS-1:0] rd_idx;
	slot_rd_t            rd;
	wr_req_t             wr;
	result_t             res;

	sprt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.segment_id (segment_id),
		.busy       (busy),
		.rd_idx     (rd_idx),
		.rd         (rd),
		.wr         (wr),
		.res        (res)
	);

	sprt_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= res.valid;
		end
	end

	// Result registers, fitted to the port widths.
	always_ff @(posedge clk) begin
		if (res.valid) begin
			status        <= res.status;
			slot_index    <= fit_slot(res.idx);
			newly_claimed <= res.claimed;
			slot_freed    <= res.freed;
			ref_count     <= fit_count(res.count);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sprt_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Holds the id and reference count of every slot. One read port at the scan
// index and one write port for the update. Reset frees every slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sprt_slot_store
	import sprt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [IDX_BITS-1:0] rd_idx,
	output slot_rd_t                 rd,
	input  wire wr_req_t             wr
);

	logic [ID_BITS-1:0]    ids_q    [SLOT_COUNT];
	logic [COUNT_BITS-1:0] counts_q [SLOT_COUNT];

	// Slot registers, cleared to the free state at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				ids_q[i]    <= '0;
				counts_q[i] <= '0;
			end
		end else if (wr.en) begin
			ids_q[wr.idx]    <= wr.id;
			counts_q[wr.idx] <= wr.count;
		end
	end

	// Read port for the scan.
	assign rd.id    = ids_q[rd_idx];
	assign rd.count = counts_q[rd_idx];

endmodule

`default_nettype wire

FILE: rtl/sprt_ctrl.sv
// ----------------------------------------------------------------------------
// Request sequencer
// Takes a request, walks the slots one per cycle through a single id
// comparator for a valid id, then decides the outcome and writes the slot back.
// ----------------------------------------------------------------------------
`default_nettype none

module sprt_ctrl
	import sprt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                action,
	input  wire logic signed [31:0]  segment_id,
	output logic                     busy,
	output logic [IDX_BITS-1:0]      rd_idx,
	input  wire slot_rd_t            rd,
	output wr_req_t                  wr,
	output result_t                  res
);

	localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(SLOT_COUNT - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t                state_q, state_d;
	logic [IDX_BITS-1:0]   idx_q;
	action_t               action_q;
	logic [ID_BITS-1:0]    id_q;
	logic                  bad_q;
	logic                  hit_q;
	logic [IDX_BITS-1:0]   hit_idx_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  free_q;
	logic [IDX_BITS-1:0]   free_idx_q;

	logic                  accept;
	logic                  id_bad;
	logic                  match;
	logic                  slot_free;
	logic                  last;
	logic [COUNT_BITS-1:0] dec_cnt;

	assign accept    = start && (state_q == ST_IDLE);
	assign id_bad    = segment_id[31] || (segment_id == 32'sd0);
	assign match     = (rd.id == id_q);
	assign slot_free = (rd.id == '0);
	assign last      = (idx_q == LAST_IDX);
	assign busy      = (state_q != ST_IDLE);
	assign rd_idx    = idx_q;
	assign dec_cnt   = (hit_cnt_q != '0) ? hit_cnt_q - 1'b1 : '0;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = id_bad ? ST_UPDATE : ST_SCAN;
			end
			ST_SCAN: begin
				if (match || last) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			bad_q  <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (accept) begin
			idx_q  <= '0;
			bad_q  <= id_bad;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (match) begin
				hit_q <= 1'b1;
			end else if (slot_free && !free_q) begin
				free_q <= 1'b1;
			end
			if (!last) idx_q <= idx_q + 1'b1;
		end
	end

	// Payload registers of the request and of the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(action);
			id_q     <= segment_id[ID_BITS-1:0];
		end
		if (state_q == ST_SCAN) begin
			if (match) begin
				hit_idx_q <= idx_q;
				hit_cnt_q <= rd.count;
			end else if (slot_free && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	// Outcome and slot write-back in the update cycle.
	always_comb begin
		res        = '0;
		res.status = STAT_OK;
		wr         = '0;
		if (state_q == ST_UPDATE) begin
			res.valid = 1'b1;
			if (bad_q) begin
				res.status = STAT_BAD_ID;
			end else if (action_q == ACT_OPEN) begin
				if (hit_q) begin
					if (hit_cnt_q == COUNT_MAX) begin
						res.status = STAT_AT_MAX;
						res.count  = hit_cnt_q;
					end else begin
						res.idx   = hit_idx_q;
						res.count = hit_cnt_q + 1'b1;
						wr.en     = 1'b1;
						wr.idx    = hit_idx_q;
						wr.id     = id_q;
						wr.count  = hit_cnt_q + 1'b1;
					end
				end else if (free_q) begin
					res.idx     = free_idx_q;
					res.claimed = 1'b1;
					res.count   = COUNT_BITS'(1);
					wr.en       = 1'b1;
					wr.idx      = free_idx_q;
					wr.id       = id_q;
					wr.count    = COUNT_BITS'(1);
				end else begin
					res.status = STAT_FULL;
				end
			end else begin
				if (!hit_q) begin
					res.status = STAT_NOT_FOUND;
				end else begin
					res.idx  = hit_idx_q;
					wr.en    = 1'b1;
					wr.idx   = hit_idx_q;
					wr.count = dec_cnt;
					if (dec_cnt == '0) begin
						res.freed = 1'b1;
						wr.id     = '0;
					end else begin
						res.count = dec_cnt;
						wr.id     = id_q;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sprt_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for request and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module sprt_checker
	import sprt_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic signed [31:0]        segment_id,
	input wire logic                      done,
	input wire logic [2:0]                status,
	input wire logic [SLOT_OUT_BITS-1:0]  slot_index,
	input wire logic                      newly_claimed,
	input wire logic                      slot_freed,
	input wire logic [COUNT_OUT_BITS-1:0] ref_count
);

	// An accepted transaction makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// A result is shown only once the block is ready again.
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A refused transaction reports no slot and no flags.
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |-> (slot_index == '0) && !newly_claimed && !slot_freed)
		else $error("refused transaction carries slot or flags");

	// A freed slot reports a zero count, and claim and free never coincide.
	a_freed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && slot_freed |-> (ref_count == '0) && !newly_claimed && (status == STAT_OK))
		else $error("freed slot with nonzero count or claim");

	// A non-positive id skips the scan and is answered straight from the update state.
	a_bad_id_fast: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (segment_id[31] || (segment_id == 32'sd0)) |-> ##2 done)
		else $error("non-positive id not answered in two cycles");

endmodule

bind shared_page_refcount_table sprt_checker u_sprt_checker (.*);

`default_nettype wire

FILE: sim/tb_shared_page_refcount_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shared page reference count table testbench
// Sends open and close transactions through the start/busy handshake and
// predicts every result from a private copy of the slot table. Directed
// tests cover rejected ids, slot claim and release and a full table; random
// traffic runs in several sender idling phases.
// ----------------------------------------------------------------------------

module tb_shared_page_refcount_table;
	import sprt_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int DRAIN_CYCLES  = 40;
	localparam int MAX_GAP       = 24;
	localparam int POOL_SIZE     = 20;
	localparam int REPORT_LIMIT  = 10;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int PHASE_ITEMS   = 75;
	localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

	// Expected content of one result transaction.
	typedef struct packed {
		status_t                    status;
		logic [SLOT_OUT_BITS-1:0]   slot;
		logic                       claimed;
		logic                       freed;
		logic [COUNT_OUT_BITS-1:0]  count;
	} outcome_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      action = 1'b0;
	logic signed [31:0]        segment_id = '0;
	logic                      busy;
	logic                      done;
	logic [2:0]                status;
	logic [SLOT_OUT_BITS-1:0]  slot_index;
	logic                      newly_claimed;
	logic                      slot_freed;
	logic [COUNT_OUT_BITS-1:0] ref_count;

	// Predicted slot table.
	logic [ID_BITS-1:0]    table_ids [SLOT_COUNT];
	logic [COUNT_BITS-1:0] table_counts [SLOT_COUNT];

	outcome_t    pending_results [$];
	logic [30:0] id_pool [POOL_SIZE];
	int          sender_idle_pct = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	shared_page_refcount_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.segment_id   (segment_id),
		.done         (done),
		.status       (status),
		.slot_index   (slot_index),
		.newly_claimed(newly_claimed),
		.slot_freed   (slot_freed),
		.ref_count    (ref_count)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Applies one request to the predicted table and returns its result.
	function automatic outcome_t apply_request(input action_t act, input logic [31:0] raw);
		outcome_t           o;
		logic [ID_BITS-1:0] id;
		int                 hit;
		int                 free_idx;
		o = '0;
		hit = -1;
		free_idx = -1;
		if (raw[31] || raw == 32'd0) begin
			o.status = STAT_BAD_ID;
			return o;
		end
		id = raw[30:0];
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (hit < 0) begin
				if (table_ids[i] == id)
					hit = i;
				else if (table_ids[i] == '0 && free_idx < 0)
					free_idx = i;
			end
		end
		if (act == ACT_OPEN) begin
			if (hit >= 0) begin
				if (table_counts[hit] == COUNT_TOP) begin
					o.status = STAT_AT_MAX;
					o.count = COUNT_OUT_BITS'(table_counts[hit]);
				end else begin
					table_counts[hit] = table_counts[hit] + 1'b1;
					o.status = STAT_OK;
					o.slot = SLOT_OUT_BITS'(hit);
					o.count = COUNT_OUT_BITS'(table_counts[hit]);
				end
			end else if (free_idx >= 0) begin
				table_ids[free_idx] = id;
				table_counts[free_idx] = COUNT_BITS'(1);
				o.status = STAT_OK;
				o.slot = SLOT_OUT_BITS'(free_idx);
				o.claimed = 1'b1;
				o.count = COUNT_OUT_BITS'(1);
			end else begin
				o.status = STAT_FULL;
			end
		end else begin
			if (hit < 0) begin
				o.status = STAT_NOT_FOUND;
			end else begin
				if (table_counts[hit] != '0)
					table_counts[hit] = table_counts[hit] - 1'b1;
				o.status = STAT_OK;
				o.slot = SLOT_OUT_BITS'(hit);
				if (table_counts[hit] == '0) begin
					table_ids[hit] = '0;
					o.freed = 1'b1;
				end else begin
					o.count = COUNT_OUT_BITS'(table_counts[hit]);
				end
			end
		end
		return o;
	endfunction

	// Sends one request transaction, with an optional idle gap in front of it.
	// Start is left high so that a back-to-back request keeps it up.
	task automatic send_request(input action_t act, input logic [31:0] raw);
		int gap;
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			gap = $urandom_range(1, MAX_GAP);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		segment_id <= raw;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_request(act, raw));
	endtask

	// Holds the sender off until every expected result has arrived.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Closes every held slot down to zero so the table is empty again.
	task automatic release_all();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			while (table_ids[i] != '0)
				send_request(ACT_CLOSE, {1'b0, table_ids[i]});
		end
		drain_results();
	endtask

	// Non-positive ids and a close of an unknown id change nothing.
	task automatic test_rejected_ids();
		sender_idle_pct = 0;
		send_request(ACT_OPEN, 32'd0);
		send_request(ACT_OPEN, 32'hFFFF_FFFF);
		send_request(ACT_OPEN, 32'h8000_0000);
		send_request(ACT_CLOSE, 32'd0);
		send_request(ACT_CLOSE, 32'h8000_0001);
		send_request(ACT_CLOSE, 32'd7);
		drain_results();
	endtask

	// Claim, reuse and release of slots, lowest free slot first.
	task automatic test_claim_release();
		sender_idle_pct = 0;
		send_request(ACT_OPEN, 32'd1);
		send_request(ACT_OPEN, 32'd1);
		send_request(ACT_OPEN, 32'h7FFF_FFFF);
		send_request(ACT_CLOSE, 32'd1);
		send_request(ACT_CLOSE, 32'd1);
		send_request(ACT_CLOSE, 32'd1);
		send_request(ACT_OPEN, 32'd5);
		send_request(ACT_CLOSE, 32'h7FFF_FFFF);
		drain_results();
	endtask

	// Fill every slot, then an open of a new id is refused while a held id
	// still opens.
	task automatic test_table_full();
		sender_idle_pct = 0;
		for (int i = 0; i < SLOT_COUNT; i++)
			send_request(ACT_OPEN, 32'h4000_0000 + 32'(i));
		send_request(ACT_OPEN, 32'd999);
		send_request(ACT_OPEN, 32'h4000_0003);
		drain_results();
		release_all();
	endtask

	// Random traffic on a small id pool so that hits, fills and frees recur.
	task automatic test_random_traffic(input int items, input int idle_pct);
		int          r;
		logic [30:0] pick;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i % 2 == 0)
				id_pool[i] = 31'($urandom_range(1, 40));
			else
				id_pool[i] = 31'($urandom()) | 31'h1;
		end
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(99);
			pick = id_pool[$urandom_range(POOL_SIZE - 1)];
			if (r < 8)
				send_request(action_t'($urandom_range(1)), $urandom());
			else if (r < 12)
				send_request(action_t'($urandom_range(1)),
					($urandom_range(1) != 0) ? 32'd0 : (32'h8000_0000 | $urandom()));
			else if (r < 62)
				send_request(ACT_OPEN, {1'b0, pick});
			else
				send_request(ACT_CLOSE, {1'b0, pick});
		end
		drain_results();
		release_all();
	endtask

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("unexpected result: status %0d slot %0d claimed %0b freed %0b count %0d",
						status, slot_index, newly_claimed, slot_freed, ref_count);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || slot_index !== want.slot ||
						newly_claimed !== want.claimed || slot_freed !== want.freed ||
						ref_count !== want.count) begin
					if (mismatch_count < REPORT_LIMIT) begin
						$display("mismatch expected: status %0d slot %0d claimed %0b freed %0b count %0d",
							want.status, want.slot, want.claimed, want.freed, want.count);
						$display("mismatch actual:   status %0d slot %0d claimed %0b freed %0b count %0d",
							status, slot_index, newly_claimed, slot_freed, ref_count);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("shared_page_refcount_table verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			table_ids[i] = '0;
			table_counts[i] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rejected_ids();
		test_claim_release();
		test_table_full();
		test_random_traffic(PHASE_ITEMS, 0);
		test_random_traffic(PHASE_ITEMS, 64);
		test_random_traffic(PHASE_ITEMS, 21);
		test_random_traffic(PHASE_ITEMS, 0);

		drain_results();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("shared_page_refcount_table verification clean");
		else
			$display("shared_page_refcount_table verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sprt_pkg.sv
rtl/sprt_slot_store.sv
rtl/sprt_ctrl.sv
rtl/shared_page_refcount_table.sv
rtl/sprt_checker.sv
sim/tb_shared_page_refcount_table.sv
